>>> hw/rtl/mldsa_challenge_mul_add_defines.svh
// Assertion macros shared by the challenge multiply-accumulate RTL.
`ifndef MLDSA_CHALLENGE_MUL_ADD_DEFINES_SVH
`define MLDSA_CHALLENGE_MUL_ADD_DEFINES_SVH

`ifndef SYNTHESIS
`define MCMA_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define MCMA_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MCMA_ASSERT_IMP(name, clk, rstn, ante, cons)
`define MCMA_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

>>> hw/rtl/mcma_pkg.sv
// Shared types and constants of the challenge multiply-accumulate block.
package mcma_pkg;

  localparam int unsigned REQ_W       = 2;
  localparam int unsigned CIDX_W      = 8;
  localparam int unsigned COEFF_W     = 32;
  localparam int unsigned POLY_W      = 3;
  localparam int unsigned CH_W        = 2;
  localparam int unsigned S_TDATA_W   = 48;
  localparam int unsigned M_TDATA_W   = 32;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned PADDR_W     = 3;

  localparam logic [POLY_W-1:0] POLY_COUNT_RST = 3'd4;
  // word index of the poly_count register
  localparam logic [PADDR_W-3:0] REG_POLY_COUNT = 1'b0;

  // stored challenge codes, two's complement
  localparam logic [CH_W-1:0] CH_ZERO = 2'b00;
  localparam logic [CH_W-1:0] CH_POS  = 2'b01;
  localparam logic [CH_W-1:0] CH_NEG  = 2'b11;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ACCUM = 2'd1,
    REQ_EMIT  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    MAC_IDLE  = 3'd0,
    MAC_LOAD  = 3'd1,
    MAC_ACCUM = 3'd2,
    MAC_EMIT  = 3'd3,
    MAC_CLEAR = 3'd4
  } mac_op_e;

  typedef struct packed {
    mac_op_e op;
    logic    wrap;     // position wrapped past the ring degree: negate term
    logic    emit_wr;  // emit clears the accumulator entry
  } mac_ctrl_t;

endpackage

>>> hw/rtl/mcma_mac.sv
// Challenge and accumulator memories with the shared add/negate unit.
module mcma_mac #(
  parameter int unsigned RING_DEGREE = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mcma_pkg::mac_ctrl_t                ctrl_i,
  input  logic [$clog2(RING_DEGREE)-1:0]     addr_i,
  input  logic [$clog2(RING_DEGREE)-1:0]     ch_addr_i,
  input  logic [mcma_pkg::CH_W-1:0]          ch_wdata_i,
  input  logic [mcma_pkg::COEFF_W-1:0]       operand_i,
  output logic [mcma_pkg::COEFF_W-1:0]       sum_o
);
  import mcma_pkg::*;

  localparam int unsigned IDX_W = $clog2(RING_DEGREE);

  logic [CH_W-1:0]    ch_mem  [RING_DEGREE];
  logic [COEFF_W-1:0] acc_mem [RING_DEGREE];

  logic [CH_W-1:0]    ch_rdata_q;
  logic [COEFF_W-1:0] acc_rdata_q;
  mac_op_e            st_op_q;
  logic               st_wrap_q;
  logic               st_emit_wr_q;
  logic [IDX_W-1:0]   st_addr_q;

  logic               neg;
  logic               nz;
  logic [COEFF_W-1:0] opnd;
  logic [COEFF_W-1:0] sum;
  logic               acc_we;
  logic [IDX_W-1:0]   acc_waddr;
  logic [COEFF_W-1:0] acc_wdata;

  // write-back stage: one adder with carry-in does add and subtract
  always_comb begin
    nz   = ch_rdata_q inside {CH_POS, CH_NEG};
    neg  = 1'b0;
    opnd = '0;
    if (st_op_q == MAC_EMIT) begin
      opnd = operand_i;
    end else if (nz) begin
      opnd = operand_i;
      neg  = (ch_rdata_q == CH_NEG) ^ st_wrap_q;
    end
    sum = acc_rdata_q + (opnd ^ {COEFF_W{neg}}) + {{(COEFF_W-1){1'b0}}, neg};
  end

  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = st_addr_q;
    acc_wdata = sum;
    if (ctrl_i.op == MAC_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = addr_i;
      acc_wdata = '0;
    end else if (st_op_q == MAC_ACCUM) begin
      acc_we = 1'b1;
    end else if (st_op_q == MAC_EMIT && st_emit_wr_q) begin
      acc_we    = 1'b1;
      acc_wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == MAC_LOAD) begin
      ch_mem[addr_i] <= ch_wdata_i;
    end else if (ctrl_i.op == MAC_CLEAR) begin
      ch_mem[addr_i] <= CH_ZERO;
    end
    ch_rdata_q <= ch_mem[ch_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_rdata_q <= acc_mem[addr_i];
    st_addr_q   <= addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_op_q      <= MAC_IDLE;
      st_wrap_q    <= 1'b0;
      st_emit_wr_q <= 1'b0;
    end else begin
      st_op_q      <= ctrl_i.op;
      st_wrap_q    <= ctrl_i.wrap;
      st_emit_wr_q <= ctrl_i.emit_wr;
    end
  end

  assign sum_o = sum;

endmodule

>>> hw/rtl/mcma_seq.sv
// Sequencer: input handshake, per-request step control and result register.
module mcma_seq #(
  parameter int unsigned RING_DEGREE = 256,
  parameter int unsigned MAX_POLYS   = 7
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_valid_i,
  output logic                                  s_ready_o,
  input  logic [mcma_pkg::REQ_W-1:0]            s_req_i,
  input  logic [mcma_pkg::CIDX_W-1:0]           s_coeff_index_i,
  input  logic signed [mcma_pkg::COEFF_W-1:0]   s_coeff_value_i,
  input  logic [mcma_pkg::POLY_W-1:0]           s_poly_index_i,
  input  logic [mcma_pkg::POLY_W-1:0]           poly_count_i,
  output logic                                  m_valid_o,
  input  logic                                  m_ready_i,
  output logic signed [mcma_pkg::COEFF_W-1:0]   m_z_coeff_o,
  output logic                                  m_status_o,
  output mcma_pkg::mac_ctrl_t                   mac_ctrl_o,
  output logic [$clog2(RING_DEGREE)-1:0]        mac_addr_o,
  output logic [$clog2(RING_DEGREE)-1:0]        mac_ch_addr_o,
  output logic [mcma_pkg::CH_W-1:0]             mac_ch_wdata_o,
  output logic [mcma_pkg::COEFF_W-1:0]          mac_operand_o,
  input  logic [mcma_pkg::COEFF_W-1:0]          mac_sum_i
);
  import mcma_pkg::*;

  localparam int unsigned IDX_W     = $clog2(RING_DEGREE);
  localparam int unsigned TBL_DEPTH = 2 ** CIDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEGREE - 1);

  typedef logic [IDX_W-1:0] pos_tbl_t [TBL_DEPTH];

  // coefficient index reduced by the ring degree, built at elaboration
  function automatic pos_tbl_t build_pos_tbl();
    pos_tbl_t tbl;
    for (int k = 0; k < TBL_DEPTH; k++) begin
      tbl[k] = IDX_W'(k % RING_DEGREE);
    end
    return tbl;
  endfunction

  localparam pos_tbl_t POS_TBL = build_pos_tbl();

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_EMIT_RD,
    ST_EMIT_WB,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic               wrap_q, wrap_d;
  logic               use_q, use_d;
  logic               clr_req_q, clr_req_d;
  logic               bad_q, bad_d;
  logic [COEFF_W-1:0] val_q, val_d;
  logic [COEFF_W-1:0] res_z_q, res_z_d;
  logic               out_valid_q, out_valid_d;
  logic [COEFF_W-1:0] out_z_q, out_z_d;
  logic               out_status_q, out_status_d;

  logic               accept;
  logic               out_load;
  logic [IDX_W-1:0]   in_pos;
  logic [CH_W-1:0]    ch_code;
  logic               ch_bad;
  logic               poly_in_use;

  assign accept      = s_valid_i && (state_q == ST_IDLE);
  assign in_pos      = POS_TBL[s_coeff_index_i];
  assign poly_in_use = (s_poly_index_i < poly_count_i) &&
                       (32'(s_poly_index_i) < MAX_POLYS);
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || m_ready_i);

  always_comb begin
    ch_code = CH_ZERO;
    ch_bad  = 1'b0;
    if (s_coeff_value_i == COEFF_W'(0)) begin
      ch_code = CH_ZERO;
    end else if (s_coeff_value_i == COEFF_W'(1)) begin
      ch_code = CH_POS;
    end else if (s_coeff_value_i == {COEFF_W{1'b1}}) begin
      ch_code = CH_NEG;
    end else begin
      ch_bad = 1'b1;
    end
  end

  // memory control
  always_comb begin
    mac_ctrl_o.op      = MAC_IDLE;
    mac_ctrl_o.wrap    = wrap_q;
    mac_ctrl_o.emit_wr = use_q;
    mac_addr_o         = pos_q;
    mac_ch_addr_o      = cnt_q;
    mac_ch_wdata_o     = ch_code;
    mac_operand_o      = val_q;
    case (state_q)
      ST_CLEAR: begin
        mac_ctrl_o.op = MAC_CLEAR;
        mac_addr_o    = cnt_q;
      end
      ST_IDLE: begin
        if (accept && req_e'(s_req_i) == REQ_LOAD) begin
          mac_ctrl_o.op = MAC_LOAD;
          mac_addr_o    = in_pos;
        end
      end
      ST_ACC:     mac_ctrl_o.op = MAC_ACCUM;
      ST_EMIT_RD: mac_ctrl_o.op = MAC_EMIT;
      default:    mac_ctrl_o.op = MAC_IDLE;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    wrap_d    = wrap_q;
    use_d     = use_q;
    clr_req_d = clr_req_q;
    bad_d     = bad_q;
    val_d     = val_q;
    res_z_d   = res_z_q;
    case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          cnt_d     = '0;
          clr_req_d = 1'b0;
          res_z_d   = '0;
          state_d   = clr_req_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (req_e'(s_req_i))
            REQ_LOAD: begin
              bad_d   = bad_q | ch_bad;
              res_z_d = '0;
              state_d = ST_DONE;
            end
            REQ_ACCUM: begin
              pos_d   = in_pos;
              wrap_d  = 1'b0;
              cnt_d   = '0;
              val_d   = s_coeff_value_i;
              state_d = ST_ACC;
            end
            REQ_EMIT: begin
              pos_d   = in_pos;
              wrap_d  = 1'b0;
              use_d   = poly_in_use;
              val_d   = s_coeff_value_i;
              state_d = ST_EMIT_RD;
            end
            REQ_CLEAR: begin
              cnt_d     = '0;
              clr_req_d = 1'b1;
              bad_d     = 1'b0;
              state_d   = ST_CLEAR;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ACC: begin
        cnt_d = cnt_q + 1'b1;
        // walk the rotated positions, flag the wrap past the top entry
        if (pos_q == LAST_IDX) begin
          pos_d  = '0;
          wrap_d = 1'b1;
        end else begin
          pos_d = pos_q + 1'b1;
        end
        if (cnt_q == LAST_IDX) begin
          cnt_d   = '0;
          res_z_d = '0;
          state_d = ST_DONE;
        end
      end
      ST_EMIT_RD: state_d = ST_EMIT_WB;
      ST_EMIT_WB: begin
        res_z_d = use_q ? mac_sum_i : '0;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output word register: holds until taken
  always_comb begin
    out_valid_d  = out_valid_q && !m_ready_i;
    out_z_d      = out_z_q;
    out_status_d = out_status_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_z_d      = res_z_q;
      out_status_d = bad_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      pos_q        <= '0;
      wrap_q       <= 1'b0;
      use_q        <= 1'b0;
      clr_req_q    <= 1'b0;
      bad_q        <= 1'b0;
      val_q        <= '0;
      res_z_q      <= '0;
      out_valid_q  <= 1'b0;
      out_z_q      <= '0;
      out_status_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      pos_q        <= pos_d;
      wrap_q       <= wrap_d;
      use_q        <= use_d;
      clr_req_q    <= clr_req_d;
      bad_q        <= bad_d;
      val_q        <= val_d;
      res_z_q      <= res_z_d;
      out_valid_q  <= out_valid_d;
      out_z_q      <= out_z_d;
      out_status_q <= out_status_d;
    end
  end

  assign s_ready_o   = (state_q == ST_IDLE);
  assign m_valid_o   = out_valid_q;
  assign m_z_coeff_o = out_z_q;
  assign m_status_o  = out_status_q;

endmodule

>>> hw/rtl/mldsa_challenge_mul_add.sv
// Top level: z = y + c*s1 over the negacyclic ring with a ternary challenge.
// One request at a time. An accumulate walks every accumulator entry through
// the single read-modify-write port of the accumulator memory, one entry per
// cycle, and a clear rewrites both memories the same way. After reset the block
// first runs a clearing pass over every entry with s_axis_tready low; APB writes
// are taken throughout. A finished result waits in the output register, so the
// next request can be accepted before the previous word is taken. status in
// m_axis_tuser is the sticky invalid-challenge flag after each request; a clear
// request resets it.
`include "mldsa_challenge_mul_add_defines.svh"
module mldsa_challenge_mul_add #(
  parameter int unsigned RING_DEGREE = 256,
  parameter int unsigned MAX_POLYS   = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] coeff_index, [39:8] coeff_value, [42:40] poly_index, [47:43] zero
  input  logic [mcma_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // [1:0] req_type
  input  logic [mcma_pkg::REQ_W-1:0]          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] z_coeff
  output logic [mcma_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // [0] status
  output logic                                m_axis_tuser,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mcma_pkg::PADDR_W-1:0]        paddr,
  input  logic [mcma_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mcma_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import mcma_pkg::*;

  localparam int unsigned IDX_W = $clog2(RING_DEGREE);

  logic [POLY_W-1:0]  poly_count_q, poly_count_d;
  logic               reg_sel;
  logic               cfg_wr;

  mac_ctrl_t          mac_ctrl;
  logic [IDX_W-1:0]   mac_addr;
  logic [IDX_W-1:0]   mac_ch_addr;
  logic [CH_W-1:0]    mac_ch_wdata;
  logic [COEFF_W-1:0] mac_operand;
  logic [COEFF_W-1:0] mac_sum;
  logic signed [COEFF_W-1:0] z_coeff;

  // register file
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_POLY_COUNT);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = reg_sel ? {{(APB_DATA_W-POLY_W){1'b0}}, poly_count_q} : '0;

  always_comb begin
    poly_count_d = poly_count_q;
    if (cfg_wr && reg_sel) begin
      poly_count_d = pwdata[POLY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_count_q <= POLY_COUNT_RST;
    end else begin
      poly_count_q <= poly_count_d;
    end
  end

  mcma_seq #(
    .RING_DEGREE (RING_DEGREE),
    .MAX_POLYS   (MAX_POLYS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_valid_i       (s_axis_tvalid),
    .s_ready_o       (s_axis_tready),
    .s_req_i         (s_axis_tuser),
    .s_coeff_index_i (s_axis_tdata[CIDX_W-1:0]),
    .s_coeff_value_i (s_axis_tdata[CIDX_W+COEFF_W-1:CIDX_W]),
    .s_poly_index_i  (s_axis_tdata[CIDX_W+COEFF_W+POLY_W-1:CIDX_W+COEFF_W]),
    .poly_count_i    (poly_count_q),
    .m_valid_o       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .m_z_coeff_o     (z_coeff),
    .m_status_o      (m_axis_tuser),
    .mac_ctrl_o      (mac_ctrl),
    .mac_addr_o      (mac_addr),
    .mac_ch_addr_o   (mac_ch_addr),
    .mac_ch_wdata_o  (mac_ch_wdata),
    .mac_operand_o   (mac_operand),
    .mac_sum_i       (mac_sum)
  );

  mcma_mac #(
    .RING_DEGREE (RING_DEGREE)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mac_ctrl),
    .addr_i     (mac_addr),
    .ch_addr_i  (mac_ch_addr),
    .ch_wdata_i (mac_ch_wdata),
    .operand_i  (mac_operand),
    .sum_o      (mac_sum)
  );

  assign m_axis_tdata = z_coeff;

  // an accepted request makes the block busy: s_axis_tready drops after every accept
  `MCMA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // poly_count changes only through an APB write
  `MCMA_ASSERT_NXT(a_cfg_hold, clk_i, rst_ni, !(psel && penable && pwrite), $stable(poly_count_q))
  // the read port shows the register that the last write stored
  `MCMA_ASSERT_IMP(a_cfg_readback, clk_i, rst_ni, reg_sel, prdata[POLY_W-1:0] == poly_count_q)

endmodule

>>> bench/mldsa_challenge_mul_add_tb.sv
// Self-checking testbench for the sparse challenge multiply-add block.
module mldsa_challenge_mul_add_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcma_pkg::*;

  localparam int unsigned RING        = 256;
  localparam int unsigned POLYS_MAX   = 7;
  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned RST_CYCLES  = 11;
  localparam int unsigned LIMIT_CYC   = 1_000_000;
  localparam int unsigned HOLD_CYC    = 700;
  localparam int unsigned SETTLE_CYC  = RING + 10;
  localparam int unsigned PHASE_ITEMS = 82;
  localparam logic [PADDR_W-3:0] REG_UNUSED = 1'b1;

  typedef struct {
    req_e             req;
    logic [7:0]       idx;
    logic [31:0]      val;
    logic [2:0]       poly;
  } mac_req_t;

  typedef struct {
    logic [31:0]      z;
    logic             status;
    longint unsigned  stamp;
  } z_word_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [REQ_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [PADDR_W-1:0]    paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  mldsa_challenge_mul_add #(
    .RING_DEGREE(RING),
    .MAX_POLYS  (POLYS_MAX)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk_i = 1'b1;
    #(HALF_PERIOD);
    clk_i = 1'b0;
    #(HALF_PERIOD);
  end

  // Shadow state of the block
  logic [CH_W-1:0] chal_shadow [RING];
  logic [31:0]     acc_shadow  [RING];
  logic            bad_shadow;
  logic [2:0]      poly_cnt_shadow = POLY_COUNT_RST;

  mac_req_t        req_pending_q [$];
  z_word_t         z_expect_q    [$];
  mac_req_t        req_offer;

  int unsigned     gen_cnt;
  int unsigned     err_cnt;
  int unsigned     word_cnt;
  int unsigned     cycle_cnt;
  int unsigned     req_cnt [4];
  int unsigned     idle_emit_cnt;
  int unsigned     gap_left;
  int unsigned     stall_left;
  int unsigned     hold_left;
  int unsigned     setting_cnt;
  bit              hold_done;
  bit              pressure_arm;
  bit              no_idle;

  task automatic clear_shadow();
    for (int k = 0; k < RING; k++) begin
      chal_shadow[k] = CH_ZERO;
      acc_shadow[k]  = '0;
    end
    bad_shadow = 1'b0;
  endtask

  // Apply one accepted request to the shadow state and queue its z word.
  task automatic predict_z_word(mac_req_t it);
    z_word_t     w;
    logic [31:0] term;
    int unsigned p;
    w.z = '0;
    case (it.req)
      REQ_LOAD: begin
        if (it.val == 32'd0) chal_shadow[it.idx] = CH_ZERO;
        else if (it.val == 32'd1) chal_shadow[it.idx] = CH_POS;
        else if (it.val == 32'hFFFF_FFFF) chal_shadow[it.idx] = CH_NEG;
        else begin
          chal_shadow[it.idx] = CH_ZERO;
          bad_shadow = 1'b1;
        end
      end
      REQ_ACCUM: begin
        for (int j = 0; j < RING; j++) begin
          if (chal_shadow[j] != CH_ZERO) begin
            term = (chal_shadow[j] == CH_POS) ? it.val : -it.val;
            p = int'(it.idx) + j;
            // negacyclic wrap: X^N = -1
            if (p >= RING) begin
              p -= RING;
              term = -term;
            end
            acc_shadow[p] += term;
          end
        end
      end
      REQ_EMIT: begin
        if (it.poly < poly_cnt_shadow && it.poly < POLYS_MAX) begin
          w.z = it.val + acc_shadow[it.idx];
          acc_shadow[it.idx] = '0;
        end else begin
          idle_emit_cnt++;
        end
      end
      default: clear_shadow();
    endcase
    w.status = bad_shadow;
    w.stamp  = $time;
    z_expect_q.push_back(w);
    req_cnt[it.req]++;
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    logic offer_now;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      offer_now = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_z_word(req_offer);
        offer_now = 1'b0;
      end
      if (!offer_now) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_pending_q.size() != 0) begin
          if (!no_idle && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 15) - 1;
          end else begin
            req_offer = req_pending_q.pop_front();
            s_axis_tdata <= {5'b0, req_offer.poly, req_offer.val, req_offer.idx};
            s_axis_tuser <= req_offer.req;
            offer_now = 1'b1;
          end
        end
      end
      s_axis_tvalid <= offer_now;
    end
  end

  // Result monitor and receiver backpressure
  always @(posedge clk_i or negedge rst_ni) begin : z_monitor
    z_word_t w;
    logic    rdy;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        word_cnt++;
        // an expectation queued in this very step cannot be answered yet
        if (z_expect_q.size() == 0 || z_expect_q[0].stamp == $time) begin
          $display("%0t: unexpected z word: expected none, got z=%h status=%0d",
                   $time, m_axis_tdata, m_axis_tuser);
          err_cnt++;
        end else begin
          w = z_expect_q.pop_front();
          if (m_axis_tdata !== w.z || m_axis_tuser !== w.status) begin
            $display("%0t: z word mismatch: expected z=%h status=%0d, got z=%h status=%0d",
                     $time, w.z, w.status, m_axis_tdata, m_axis_tuser);
            err_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (pressure_arm && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYC - 1;
        rdy = 1'b0;
      end else if (no_idle) begin
        rdy = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_axis_tready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYC) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_req(req_e r, logic [7:0] i, logic [31:0] v, logic [2:0] p);
    mac_req_t it;
    it.req  = r;
    it.idx  = i;
    it.val  = v;
    it.poly = p;
    req_pending_q.push_back(it);
    gen_cnt++;
  endtask

  function automatic logic [31:0] small_val(int span);
    int t;
    t = int'($urandom_range(0, 2 * span)) - span;
    return 32'(t);
  endfunction

  function automatic logic [31:0] pick_challenge();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 9) return 32'd1;
    if (r < 18) return 32'hFFFF_FFFF;
    if (r == 18) return 32'd0;
    return $urandom();
  endfunction

  // One polynomial: an optional clear, load the challenge, accumulate secrets, emit z.
  task automatic queue_poly_round();
    int unsigned n_ch;
    int unsigned n_sec;
    int unsigned n_emit;
    logic [2:0]  p;
    if ($urandom_range(0, 3) != 0)
      push_req(REQ_CLEAR, 8'($urandom()), $urandom(), 3'($urandom()));
    n_ch = $urandom_range(1, 8);
    repeat (n_ch) push_req(REQ_LOAD, 8'($urandom()), pick_challenge(), 3'($urandom()));
    n_sec = $urandom_range(1, 3);
    repeat (n_sec) begin
      push_req(REQ_ACCUM, 8'($urandom()),
               ($urandom_range(0, 1) != 0) ? small_val(4) : $urandom(), 3'($urandom()));
    end
    n_emit = $urandom_range(2, 10);
    repeat (n_emit) begin
      if ($urandom_range(0, 3) == 0 || poly_cnt_shadow == 0) p = 3'($urandom_range(0, 7));
      else p = 3'($urandom_range(0, int'(poly_cnt_shadow) - 1));
      push_req(REQ_EMIT, 8'($urandom()),
               ($urandom_range(0, 1) != 0) ? small_val(1000) : $urandom(), p);
    end
    // stray request in the middle of nowhere
    if ($urandom_range(0, 7) == 0)
      push_req(req_e'($urandom_range(0, 3)), 8'($urandom()), $urandom(), 3'($urandom()));
  endtask

  task automatic wait_idle();
    while (req_pending_q.size() != 0 || s_axis_tvalid || z_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [PADDR_W-3:0] reg_idx, logic [APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_POLY_COUNT) poly_cnt_shadow = data[2:0];
    @(negedge clk_i);
  endtask

  task automatic apb_check_poly_count();
    logic [APB_DATA_W-1:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_POLY_COUNT, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    got = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    if (got !== APB_DATA_W'(poly_cnt_shadow)) begin
      $display("%0t: poly_count readback mismatch: expected %h, got %h",
               $time, APB_DATA_W'(poly_cnt_shadow), got);
      err_cnt++;
    end
  endtask

  initial begin : stimulus
    int          settings [9];
    int unsigned phase_goal;
    settings = '{7, 1, 0, 3, 5, 2, 6, 4, 7};
    clear_shadow();
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    apb_check_poly_count();

    // Directed: extremes, invalid challenges, wrap-around, unused polynomials
    push_req(REQ_CLEAR, 8'd0,   32'd0,          3'd0);
    push_req(REQ_LOAD,  8'd0,   32'd1,          3'd0);
    push_req(REQ_LOAD,  8'd255, 32'hFFFF_FFFF,  3'd7);
    push_req(REQ_LOAD,  8'd5,   32'd0,          3'd0);
    push_req(REQ_LOAD,  8'd7,   32'd2,          3'd0);
    push_req(REQ_LOAD,  8'd9,   32'h8000_0000,  3'd0);
    push_req(REQ_ACCUM, 8'd0,   32'h7FFF_FFFF,  3'd0);
    push_req(REQ_ACCUM, 8'd255, 32'h8000_0000,  3'd7);
    push_req(REQ_ACCUM, 8'd1,   32'hFFFF_FFFF,  3'd0);
    push_req(REQ_EMIT,  8'd0,   32'h7FFF_FFFF,  3'd0);
    push_req(REQ_EMIT,  8'd255, 32'h8000_0000,  3'd3);
    push_req(REQ_EMIT,  8'd1,   32'd5,          3'd4);
    push_req(REQ_EMIT,  8'd254, 32'd1,          3'd7);
    push_req(REQ_EMIT,  8'd0,   32'd0,          3'd0);
    push_req(REQ_CLEAR, 8'd255, 32'hFFFF_FFFF,  3'd7);
    push_req(REQ_LOAD,  8'd128, 32'd1,          3'd0);
    push_req(REQ_ACCUM, 8'd200, 32'd12345,      3'd0);
    push_req(REQ_EMIT,  8'd72,  32'hFFFF_FFFF,  3'd2);
    push_req(REQ_EMIT,  8'd72,  32'd0,          3'd1);
    wait_idle();

    phase_goal = gen_cnt;
    foreach (settings[k]) begin
      apb_write(REG_POLY_COUNT, APB_DATA_W'(settings[k]));
      setting_cnt++;
      // the second register slot takes no effect
      if (k == 2) apb_write(REG_UNUSED, $urandom());
      apb_check_poly_count();
      if (k == $size(settings) - 1) no_idle = 1'b1;
      phase_goal += PHASE_ITEMS;
      while (gen_cnt < phase_goal) queue_poly_round();
      @(negedge clk_i);
      if (k == 3) pressure_arm = 1'b1;
      wait_idle();
    end

    repeat (SETTLE_CYC) @(negedge clk_i);
    $display("Covered %0d requests: %0d loads, %0d accumulates, %0d emits, %0d clears",
             gen_cnt, req_cnt[REQ_LOAD], req_cnt[REQ_ACCUM], req_cnt[REQ_EMIT],
             req_cnt[REQ_CLEAR]);
    $display("Checked %0d z words over %0d poly_count settings, %0d emits out of use",
             word_cnt, setting_cnt, idle_emit_cnt);
    if (err_cnt == 0 && z_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
